FILE: hdl/crb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

	localparam int unsigned VAL_W      = 64;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned PROD_W     = 2 * VAL_W;
	localparam int unsigned SAT_W      = 59;
	localparam int unsigned COORD_W    = 24;
	localparam int unsigned RZ_W       = 32;
	localparam int unsigned TOL_W      = 16;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned ADDR_W     = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic signed [COORD_W-1:0] SEARCH_LOW_RST  = -24'sd6553600;
	localparam logic signed [COORD_W-1:0] SEARCH_HIGH_RST = 24'sd6553600;
	localparam logic [TOL_W-1:0]          TOLERANCE_RST   = 16'd1;
	localparam logic [STEP_W-1:0]         ITER_LIMIT_RST  = 6'd48;
	localparam logic signed [COORD_W-1:0] COEF_CUBIC_RST  = 24'sd65536;
	localparam logic signed [COORD_W-1:0] COEF_SQUARE_RST = 24'sd65536;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_TOLERANCE  = 2'd0,
		ST_EXACT      = 2'd1,
		ST_NO_BRACKET = 2'd2,
		ST_LIMIT      = 2'd3
	} status_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_SEARCH_LOW  = 3'd0,
		REG_SEARCH_HIGH = 3'd1,
		REG_TOLERANCE   = 3'd2,
		REG_ITER_LIMIT  = 3'd3,
		REG_COEF_CUBIC  = 3'd4,
		REG_COEF_SQUARE = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic start;
		val_t a;
		val_t b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		val_t res;
	} mul_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/crb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface crb_in_if import crb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  x_value;
	logic signed [RZ_W-1:0]     r_value;

	modport source (output valid, x_value, r_value, input ready);
	modport sink (input valid, x_value, r_value, output ready);
endinterface

interface crb_out_if import crb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  root;
	status_t                    status;
	logic [STEP_W-1:0]          steps_used;

	modport source (output valid, root, status, steps_used, input ready);
	modport sink (input valid, root, status, steps_used, output ready);
endinterface

interface crb_cfg_if import crb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ADDR_W-1:0]          addr;
	logic [CFG_DATA_W-1:0]      data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/crb_qmul.sv
`timescale 1ns / 1ps
`default_nettype none

module crb_qmul import crb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  mul_req_t  req,
	output mul_rsp_t  rsp
);

	localparam logic [2:0] PH_LAST = 3'd5;

	logic [VAL_W-1:0]    ma_q;
	logic [VAL_W-1:0]    mb_q;
	logic                neg_q;
	logic                busy_q;
	logic [2:0]          ph_q;
	logic [VAL_W-1:0]    pp_q;
	logic [1:0]          ppsh_q;
	logic                ppv_q;
	logic [PROD_W-1:0]   acc_q;

	logic [VAL_W-1:0]    a_mag;
	logic [VAL_W-1:0]    b_mag;
	logic [HALF_W-1:0]   a_chunk;
	logic [HALF_W-1:0]   b_chunk;
	logic [VAL_W-1:0]    pp_next;
	logic [PROD_W-1:0]   pp_shifted;
	logic                sat;
	logic [SAT_W-1:0]    mag;

	assign a_mag   = req.a[VAL_W-1] ? VAL_W'(-req.a) : VAL_W'(req.a);
	assign b_mag   = req.b[VAL_W-1] ? VAL_W'(-req.b) : VAL_W'(req.b);
	assign a_chunk = ph_q[1] ? ma_q[VAL_W-1:HALF_W] : ma_q[HALF_W-1:0];
	assign b_chunk = ph_q[0] ? mb_q[VAL_W-1:HALF_W] : mb_q[HALF_W-1:0];
	assign pp_next = VAL_W'(a_chunk) * VAL_W'(b_chunk);

	always_comb begin
		unique case (ppsh_q)
			2'd0:    pp_shifted = PROD_W'(pp_q);
			2'd1:    pp_shifted = PROD_W'(pp_q) << HALF_W;
			2'd2:    pp_shifted = PROD_W'(pp_q) << (2 * HALF_W);
			default: pp_shifted = '0;
		endcase
	end

	assign sat     = (acc_q >> (FRAC_BITS + SAT_W)) != '0;
	assign mag     = sat ? {SAT_W{1'b1}} : acc_q[FRAC_BITS+SAT_W-1:FRAC_BITS];
	assign rsp.res = neg_q ? -val_t'(VAL_W'(mag)) : val_t'(VAL_W'(mag));
	assign rsp.done = busy_q && (ph_q == PH_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
			ppv_q  <= 1'b0;
		end else if (!busy_q) begin
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
				ppv_q  <= 1'b0;
			end
		end else begin
			ppv_q <= !ph_q[2];
			ph_q  <= ph_q + 3'd1;
			if (ph_q == PH_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				ma_q  <= a_mag;
				mb_q  <= b_mag;
				neg_q <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
				acc_q <= '0;
			end
		end else begin
			if (!ph_q[2]) begin
				pp_q   <= pp_next;
				ppsh_q <= {1'b0, ph_q[1]} + {1'b0, ph_q[0]};
			end
			if (ppv_q) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cubic_root_bisection.sv
// Bisection root finder for f(y) = -u*y^3 + p*y^2 - (u*x^2 - rz)*y + p*x^2 in signed fixed point.
// The operand channel carries x_value and r_value; one transaction there yields exactly one
// transaction on the result channel carrying root, status and steps_used.
// The cfg channel is always ready and writes the interval ends, tolerance, iteration limit and
// the coefficients u and p; it is meant to be used only while no item is in flight.
// All multiplications share one 32 by 32 bit multiplier, which builds each product from four
// partial products. Setting up an item takes 3 multiplications and each evaluation of f takes
// 5 multiplications followed by a decision state.
// The operand channel is ready only while the sequencer is idle, so one item is computed at a time.
// A finished result moves into an output register and is held there until the receiver takes
// it; the next item is accepted meanwhile and, once computed, waits until that register is free.
// Reset returns the block to idle, drops any item in flight and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module cubic_root_bisection import crb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	crb_in_if.sink    operand,
	crb_out_if.source result,
	crb_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_X2,
		S_LIN,
		S_PX2,
		S_Y2,
		S_Y3,
		S_CUB,
		S_SQR,
		S_LINT,
		S_DECIDE,
		S_MID,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_LO,
		PH_HI,
		PH_MID
	} phase_t;

	logic signed [COORD_W-1:0] search_low_q;
	logic signed [COORD_W-1:0] search_high_q;
	logic [TOL_W-1:0]          tolerance_q;
	logic [STEP_W-1:0]         iter_limit_q;
	logic signed [COORD_W-1:0] coef_cubic_q;
	logic signed [COORD_W-1:0] coef_square_q;

	state_t                    state_q;
	state_t                    mul_next;
	phase_t                    phase_q;
	logic                      issued_q;
	logic [STEP_W-1:0]         steps_q;
	status_t                   status_q;
	logic signed [COORD_W-1:0] root_q;

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] out_root_q;
	status_t                   out_status_q;
	logic [STEP_W-1:0]         out_steps_q;

	logic signed [COORD_W-1:0] x_q;
	logic signed [RZ_W-1:0]    rz_q;
	val_t                      x2_q;
	val_t                      lin_q;
	val_t                      d_q;
	logic signed [COORD_W-1:0] y_q;
	val_t                      y2_q;
	val_t                      y3_q;
	val_t                      f_q;
	val_t                      flo_q;
	logic signed [COORD_W-1:0] lo_q;
	logic signed [COORD_W-1:0] hi_q;
	logic signed [COORD_W-1:0] mid_q;

	mul_req_t                  mreq;
	mul_rsp_t                  mrsp;
	logic                      is_mul;
	logic                      mul_done;
	logic signed [COORD_W:0]   mid_sum;
	logic signed [COORD_W-1:0] mid_next;
	logic [VAL_W-1:0]          f_mag;
	logic                      below_tol;
	logic [STEP_W-1:0]         limit_eff;
	logic [STEP_W-1:0]         steps_next;
	logic                      accept;
	logic                      out_load;

	crb_qmul #(
		.FRAC_BITS (FRAC_BITS)
	) u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign accept = operand.valid && operand.ready;

	always_comb begin
		is_mul   = 1'b1;
		mreq.a   = '0;
		mreq.b   = '0;
		mul_next = S_IDLE;
		unique case (state_q)
			S_X2: begin
				mreq.a = VAL_W'(x_q);
				mreq.b = VAL_W'(x_q);
				mul_next = S_LIN;
			end
			S_LIN: begin
				mreq.a = VAL_W'(coef_cubic_q);
				mreq.b = x2_q;
				mul_next = S_PX2;
			end
			S_PX2: begin
				mreq.a = VAL_W'(coef_square_q);
				mreq.b = x2_q;
				mul_next = S_Y2;
			end
			S_Y2: begin
				mreq.a = VAL_W'(y_q);
				mreq.b = VAL_W'(y_q);
				mul_next = S_Y3;
			end
			S_Y3: begin
				mreq.a = y2_q;
				mreq.b = VAL_W'(y_q);
				mul_next = S_CUB;
			end
			S_CUB: begin
				mreq.a = VAL_W'(coef_cubic_q);
				mreq.b = y3_q;
				mul_next = S_SQR;
			end
			S_SQR: begin
				mreq.a = VAL_W'(coef_square_q);
				mreq.b = y2_q;
				mul_next = S_LINT;
			end
			S_LINT: begin
				mreq.a = lin_q;
				mreq.b = VAL_W'(y_q);
				mul_next = S_DECIDE;
			end
			default: begin
				is_mul = 1'b0;
			end
		endcase
		mreq.start = is_mul && !issued_q;
	end

	assign mul_done   = is_mul && mrsp.done;

	assign mid_sum    = (COORD_W+1)'(lo_q) + (COORD_W+1)'(hi_q);
	assign mid_next   = mid_sum[COORD_W:1];
	assign f_mag      = f_q[VAL_W-1] ? VAL_W'(-f_q) : VAL_W'(f_q);
	assign below_tol  = f_mag < VAL_W'(tolerance_q);
	assign limit_eff  = (iter_limit_q == '0) ? STEP_W'(1) : iter_limit_q;
	assign steps_next = steps_q + STEP_W'(1);
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || result.ready);

	assign operand.ready     = (state_q == S_IDLE);
	assign result.valid      = out_valid_q;
	assign result.root       = out_root_q;
	assign result.status     = out_status_q;
	assign result.steps_used = out_steps_q;
	assign cfg.ready         = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_low_q  <= SEARCH_LOW_RST;
			search_high_q <= SEARCH_HIGH_RST;
			tolerance_q   <= TOLERANCE_RST;
			iter_limit_q  <= ITER_LIMIT_RST;
			coef_cubic_q  <= COEF_CUBIC_RST;
			coef_square_q <= COEF_SQUARE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_SEARCH_LOW:  search_low_q  <= cfg.data[COORD_W-1:0];
				REG_SEARCH_HIGH: search_high_q <= cfg.data[COORD_W-1:0];
				REG_TOLERANCE:   tolerance_q   <= cfg.data[TOL_W-1:0];
				REG_ITER_LIMIT:  iter_limit_q  <= cfg.data[STEP_W-1:0];
				REG_COEF_CUBIC:  coef_cubic_q  <= cfg.data[COORD_W-1:0];
				REG_COEF_SQUARE: coef_square_q <= cfg.data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_LO;
			issued_q     <= 1'b0;
			steps_q      <= '0;
			status_q     <= ST_TOLERANCE;
			root_q       <= '0;
			out_valid_q  <= 1'b0;
			out_root_q   <= '0;
			out_status_q <= ST_TOLERANCE;
			out_steps_q  <= '0;
		end else begin
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end
			if (mul_done) begin
				state_q <= mul_next;
			end
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_root_q   <= root_q;
				out_status_q <= status_q;
				out_steps_q  <= steps_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_X2;
						phase_q <= PH_LO;
						steps_q <= '0;
					end
				end
				S_DECIDE: begin
					unique case (phase_q)
						PH_LO: begin
							phase_q <= PH_HI;
							state_q <= S_Y2;
						end
						PH_HI: begin
							priority if (flo_q == '0) begin
								root_q   <= lo_q;
								status_q <= ST_EXACT;
								state_q  <= S_OUT;
							end else if (f_q == '0) begin
								root_q   <= hi_q;
								status_q <= ST_EXACT;
								state_q  <= S_OUT;
							end else if (flo_q[VAL_W-1] == f_q[VAL_W-1]) begin
								root_q   <= '0;
								status_q <= ST_NO_BRACKET;
								state_q  <= S_OUT;
							end else begin
								phase_q <= PH_MID;
								state_q <= S_MID;
							end
						end
						default: begin
							steps_q <= steps_next;
							root_q  <= mid_q;
							priority if (f_q == '0) begin
								status_q <= ST_EXACT;
								state_q  <= S_OUT;
							end else if (below_tol) begin
								status_q <= ST_TOLERANCE;
								state_q  <= S_OUT;
							end else if (steps_next >= limit_eff) begin
								status_q <= ST_LIMIT;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_MID;
							end
						end
					endcase
				end
				S_MID: begin
					state_q <= S_Y2;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q  <= operand.x_value;
			rz_q <= operand.r_value;
			lo_q <= search_low_q;
			hi_q <= search_high_q;
			y_q  <= search_low_q;
		end
		if (mul_done) begin
			unique case (state_q)
				S_X2:    x2_q  <= mrsp.res;
				S_LIN:   lin_q <= mrsp.res - VAL_W'(rz_q);
				S_PX2:   d_q   <= mrsp.res;
				S_Y2:    y2_q  <= mrsp.res;
				S_Y3:    y3_q  <= mrsp.res;
				S_CUB:   f_q   <= d_q - mrsp.res;
				S_SQR:   f_q   <= f_q + mrsp.res;
				S_LINT:  f_q   <= f_q - mrsp.res;
				default: ;
			endcase
		end
		if (state_q == S_DECIDE) begin
			if (phase_q == PH_LO) begin
				flo_q <= f_q;
				y_q   <= hi_q;
			end else if (phase_q == PH_MID) begin
				if (f_q[VAL_W-1] != flo_q[VAL_W-1]) begin
					hi_q <= mid_q;
				end else begin
					lo_q  <= mid_q;
					flo_q <= f_q;
				end
			end
		end
		if (state_q == S_MID) begin
			mid_q <= mid_next;
			y_q   <= mid_next;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		operand.valid && operand.ready |=> !operand.ready)
		else $error("Operand channel ready while an item is in flight.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready
		|=> result.valid && $stable(result.root) && $stable(result.status)
			&& $stable(result.steps_used))
		else $error("Pending result changed before the receiver took it.");

	a_no_bracket_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_NO_BRACKET
		|-> result.steps_used == '0 && result.root == '0)
		else $error("No-bracket result carries steps or a root.");

	a_mul_done_requested: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> issued_q && is_mul)
		else $error("Multiplier finished without a pending request.");

endmodule

`default_nettype wire

FILE: dv/cubic_root_bisection_tb.sv
`timescale 1ns / 1ps

module cubic_root_bisection_tb;
	import crb_pkg::*;

	localparam int unsigned FRAC = 16;
	localparam longint SAT_LIM = 64'sh07FF_FFFF_FFFF_FFFF;
	localparam int Q_ONE = 65536;
	localparam logic [ADDR_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [ADDR_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int HOLD_CYCLES = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 115;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic signed [COORD_W-1:0] root;
		status_t                   status;
		logic [STEP_W-1:0]         steps;
	} root_outcome_t;

	logic clk;
	logic arst_n;

	crb_in_if  operand_bus ();
	crb_out_if result_bus ();
	crb_cfg_if cfg_bus ();

	cubic_root_bisection #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand_bus),
		.result(result_bus),
		.cfg(cfg_bus)
	);

	// Shadow copy of the configuration registers.
	longint lo_end;
	longint hi_end;
	longint cubic_coef;
	longint square_coef;
	longint tol_q;
	int unsigned limit_q;

	root_outcome_t pending_roots[$];
	int unsigned errors;
	bit calm;
	int unsigned hold_requests;
	int unsigned hold_seen;
	int unsigned hold_left;

	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] ma;
		logic [63:0] mb;
		logic [127:0] wide;
		longint mag;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		wide = ({64'd0, ma} * {64'd0, mb}) >> FRAC;
		if (wide > 128'(SAT_LIM)) begin
			mag = SAT_LIM;
		end else begin
			mag = longint'(wide[63:0]);
		end
		return ((a < 0) != (b < 0)) ? -mag : mag;
	endfunction

	function automatic longint cubic_at(longint y, longint x2, longint lin);
		longint y2;
		longint y3;
		y2 = fx_mul(y, y);
		y3 = fx_mul(y2, y);
		return -fx_mul(cubic_coef, y3) + fx_mul(square_coef, y2) - fx_mul(lin, y)
			+ fx_mul(square_coef, x2);
	endfunction

	function automatic root_outcome_t bisect_root(logic signed [COORD_W-1:0] x,
			logic signed [RZ_W-1:0] r);
		longint xv;
		longint rv;
		longint x2;
		longint lin;
		longint lo;
		longint hi;
		longint flo;
		longint fhi;
		longint fm;
		longint mid;
		longint mag;
		int unsigned steps;
		int unsigned cap;
		root_outcome_t res;
		xv = longint'(x);
		rv = longint'(r);
		x2 = fx_mul(xv, xv);
		lin = fx_mul(cubic_coef, x2) - rv;
		lo = lo_end;
		hi = hi_end;
		mid = 0;
		steps = 0;
		cap = (limit_q == 0) ? 1 : limit_q;
		flo = cubic_at(lo, x2, lin);
		fhi = cubic_at(hi, x2, lin);
		res.steps = '0;
		if (flo == 0) begin
			res.root = lo[COORD_W-1:0];
			res.status = ST_EXACT;
		end else if (fhi == 0) begin
			res.root = hi[COORD_W-1:0];
			res.status = ST_EXACT;
		end else if ((flo < 0) == (fhi < 0)) begin
			res.root = '0;
			res.status = ST_NO_BRACKET;
		end else begin
			res.status = ST_LIMIT;
			while (steps < cap) begin
				mid = (lo + hi) >>> 1;
				fm = cubic_at(mid, x2, lin);
				steps++;
				if (fm == 0) begin
					res.status = ST_EXACT;
					break;
				end
				if ((fm < 0) != (flo < 0)) begin
					hi = mid;
				end else begin
					lo = mid;
					flo = fm;
				end
				mag = (fm < 0) ? -fm : fm;
				if (mag < tol_q) begin
					res.status = ST_TOLERANCE;
					break;
				end
			end
			res.root = mid[COORD_W-1:0];
			res.steps = steps[STEP_W-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		operand_bus.valid = 1'b0;
		while (pending_roots.size() != 0) @(negedge clk);
	endtask

	task automatic cfg_write(logic [ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_bus.valid = 1'b1;
		cfg_bus.addr = index;
		cfg_bus.data = value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (index)
			REG_SEARCH_LOW:  lo_end = longint'($signed(value));
			REG_SEARCH_HIGH: hi_end = longint'($signed(value));
			REG_TOLERANCE:   tol_q = longint'(value[TOL_W-1:0]);
			REG_ITER_LIMIT:  limit_q = 32'(value[STEP_W-1:0]);
			REG_COEF_CUBIC:  cubic_coef = longint'($signed(value));
			REG_COEF_SQUARE: square_coef = longint'($signed(value));
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic send_operand(logic [COORD_W-1:0] x, logic [RZ_W-1:0] r);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 10) begin
			operand_bus.valid = 1'b0;
			@(negedge clk);
		end
		operand_bus.valid = 1'b1;
		operand_bus.x_value = x;
		operand_bus.r_value = r;
		do @(posedge clk); while (!operand_bus.ready);
		pending_roots.push_back(bisect_root(x, r));
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_end();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2, 3: return 24'($urandom);
			default: return 24'($urandom_range(0, 32 * Q_ONE) - 16 * Q_ONE);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2, 3: return 24'($urandom);
			default: return 24'($urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_x();
		case ($urandom_range(0, 2))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 16 * Q_ONE) - 8 * Q_ONE);
			default: return 24'($urandom_range(0, 512) - 256);
		endcase
	endfunction

	function automatic logic [RZ_W-1:0] pick_r();
		if ($urandom_range(0, 1) == 0) begin
			return 32'($urandom);
		end
		return 32'($urandom_range(0, 128 * Q_ONE) - 64 * Q_ONE);
	endfunction

	task automatic test_extreme_operands();
		logic [COORD_W-1:0] xs[3] = '{24'h800000, 24'h7FFFFF, 24'h000000};
		logic [RZ_W-1:0] rs[3] = '{32'h80000000, 32'h7FFFFFFF, 32'h00000000};
		foreach (xs[i]) begin
			foreach (rs[j]) begin
				send_operand(xs[i], rs[j]);
			end
		end
	endtask

	task automatic test_exact_ends();
		cfg_write(REG_SEARCH_LOW, '0);
		send_operand('0, RZ_W'(Q_ONE));
		cfg_write(REG_SEARCH_LOW, CFG_DATA_W'(-2 * Q_ONE));
		cfg_write(REG_SEARCH_HIGH, '0);
		send_operand('0, RZ_W'(Q_ONE));
	endtask

	task automatic test_bracket_cases();
		cfg_write(REG_SEARCH_LOW, CFG_DATA_W'(-Q_ONE));
		cfg_write(REG_SEARCH_HIGH, CFG_DATA_W'(Q_ONE));
		send_operand('0, RZ_W'(Q_ONE));
		send_operand('0, RZ_W'(3 * Q_ONE));
		cfg_write(REG_SEARCH_LOW, CFG_DATA_W'(100 * Q_ONE));
		cfg_write(REG_SEARCH_HIGH, CFG_DATA_W'(-100 * Q_ONE));
		send_operand(COORD_W'(98304), RZ_W'(45875));
	endtask

	task automatic test_limits_and_tolerance();
		cfg_write(REG_SEARCH_LOW, CFG_DATA_W'(-100 * Q_ONE));
		cfg_write(REG_SEARCH_HIGH, CFG_DATA_W'(100 * Q_ONE));
		cfg_write(REG_ITER_LIMIT, '0);
		send_operand(COORD_W'(98304), RZ_W'(45875));
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(1));
		send_operand(COORD_W'(98304), RZ_W'(45875));
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(63));
		cfg_write(REG_TOLERANCE, '0);
		send_operand(COORD_W'(98304), RZ_W'(45875));
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(48));
		cfg_write(REG_TOLERANCE, 24'hFFFFFF);
		send_operand(COORD_W'(98304), RZ_W'(45875));
	endtask

	task automatic test_adjacent_ends();
		cfg_write(REG_COEF_CUBIC, '0);
		cfg_write(REG_COEF_SQUARE, CFG_DATA_W'(Q_ONE));
		cfg_write(REG_SEARCH_LOW, CFG_DATA_W'(-3));
		cfg_write(REG_SEARCH_HIGH, CFG_DATA_W'(-2));
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(5));
		cfg_write(REG_TOLERANCE, CFG_DATA_W'(1));
		send_operand(COORD_W'(Q_ONE), 32'h7FFFFFFF);
	endtask

	task automatic test_extreme_settings();
		cfg_write(REG_SEARCH_LOW, 24'h800000);
		cfg_write(REG_SEARCH_HIGH, 24'h7FFFFF);
		cfg_write(REG_COEF_CUBIC, 24'h800000);
		cfg_write(REG_COEF_SQUARE, 24'h7FFFFF);
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(8));
		send_operand(24'h7FFFFF, 32'h80000000);
		send_operand(24'h800000, 32'h7FFFFFFF);
		// Writes to unassigned indexes must leave every register alone.
		cfg_write(REG_UNUSED_LO, 24'hFFFFFF);
		cfg_write(REG_UNUSED_HI, 24'h000000);
		send_operand(COORD_W'(Q_ONE), RZ_W'(-Q_ONE));
	endtask

	task automatic test_receiver_hold();
		cfg_write(REG_ITER_LIMIT, CFG_DATA_W'(2));
		hold_requests++;
		for (int n = 0; n < 6; n++) begin
			send_operand(pick_x(), pick_r());
		end
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			calm = (ph == 2);
			cfg_write(REG_SEARCH_LOW, pick_end());
			cfg_write(REG_SEARCH_HIGH, pick_end());
			cfg_write(REG_TOLERANCE, {8'($urandom), ($urandom_range(0, 2) == 0) ?
				16'($urandom) : 16'($urandom_range(0, 64))});
			cfg_write(REG_ITER_LIMIT, {18'($urandom), ($urandom_range(0, 3) == 0) ?
				6'($urandom_range(17, 63)) : 6'($urandom_range(0, 16))});
			cfg_write(REG_COEF_CUBIC, pick_coef());
			cfg_write(REG_COEF_SQUARE, pick_coef());
			if ($urandom_range(0, 3) == 0) begin
				cfg_write(REG_UNUSED_HI, 24'($urandom));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_operand(pick_x(), pick_r());
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random, and for a long stretch whenever a hold is requested.
	initial begin
		result_bus.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				result_bus.ready = 1'b0;
				hold_left--;
			end else begin
				result_bus.ready = calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	always @(posedge clk) begin
		root_outcome_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_roots.size() == 0) begin
				report_mismatch($sformatf("result transaction with no item outstanding, root %0d",
					result_bus.root));
			end else begin
				want = pending_roots.pop_front();
				if (result_bus.root !== want.root) begin
					report_mismatch($sformatf("root got %0d, expected %0d",
						result_bus.root, want.root));
				end
				if (result_bus.status !== want.status) begin
					report_mismatch($sformatf("status got %0d, expected %0d",
						result_bus.status, want.status));
				end
				if (result_bus.steps_used !== want.steps) begin
					report_mismatch($sformatf("steps_used got %0d, expected %0d",
						result_bus.steps_used, want.steps));
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		errors = 0;
		calm = 1'b0;
		hold_requests = 0;
		operand_bus.valid = 1'b0;
		operand_bus.x_value = '0;
		operand_bus.r_value = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.addr = REG_SEARCH_LOW;
		cfg_bus.data = '0;
		lo_end = longint'(SEARCH_LOW_RST);
		hi_end = longint'(SEARCH_HIGH_RST);
		tol_q = longint'(TOLERANCE_RST);
		limit_q = 32'(ITER_LIMIT_RST);
		cubic_coef = longint'(COEF_CUBIC_RST);
		square_coef = longint'(COEF_SQUARE_RST);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extreme_operands();
		test_exact_ends();
		test_bracket_cases();
		test_limits_and_tolerance();
		test_adjacent_ends();
		test_extreme_settings();
		test_receiver_hold();
		test_random_phases();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/crb_pkg.sv
hdl/crb_if.sv
hdl/crb_qmul.sv
hdl/cubic_root_bisection.sv
dv/cubic_root_bisection_tb.sv
